>>> rtl/core/bounded_sorted_score_table_macros.svh
// assertion macros for the bounded sorted score table
// used by the controller and the datapath; expects clk_i and rst_ni in scope
`ifndef BOUNDED_SORTED_SCORE_TABLE_MACROS_SVH
`define BOUNDED_SORTED_SCORE_TABLE_MACROS_SVH

// same-cycle implication
`define BSST_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("bsst assertion failed");

// next-cycle implication
`define BSST_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("bsst assertion failed");

`endif

>>> rtl/core/bsst_pkg.sv
// shared types and constants of the bounded sorted score table
// no dependencies; used by bsst_ctrl, bsst_dpath and the top level
package bsst_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned SCORE_W      = 32;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CNT_OUT_W    = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_INVALID  = 2'd3
  } status_e;

  // datapath micro-operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_INS_FULL_RD,
    DP_INS_OPEN,
    DP_INS_HOLE_LAST,
    DP_WALK_RD,
    DP_WALK_MOVE,
    DP_INS_PUT,
    DP_REJECT,
    DP_INVALID,
    DP_RM_RD,
    DP_RM_TAKE,
    DP_RM_SHIFT,
    DP_RM_END,
    DP_OUT
  } dp_op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic full;
    logic gt;
    logic idx_zero;
    logic idx_one;
    logic pos_bad;
    logic idx_lt_held;
  } dp_stat_t;

endpackage

>>> rtl/core/bsst_ctrl.sv
// controller state machine of the bounded sorted score table
// depends on bsst_pkg and bounded_sorted_score_table_macros.svh
`include "bounded_sorted_score_table_macros.svh"

module bsst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bsst_pkg::dp_stat_t stat_i,
  output bsst_pkg::dp_op_e  dp_op_o
);
  import bsst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_START,
    S_INS_CHK,
    S_WALK_RD,
    S_WALK,
    S_PUT,
    S_RM_START,
    S_RM_TAKE,
    S_RM_SHIFT,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // next state and micro-op
  always_comb begin
    state_d     = state_q;
    dp_op_o     = DP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          dp_op_o = DP_LOAD;
          state_d = op_i ? S_RM_START : S_INS_START;
        end
      end
      S_INS_START: begin
        if (stat_i.full) begin
          dp_op_o = DP_INS_FULL_RD;
          state_d = S_INS_CHK;
        end else begin
          dp_op_o = DP_INS_OPEN;
          state_d = S_WALK_RD;
        end
      end
      S_INS_CHK: begin
        if (stat_i.gt) begin
          dp_op_o = DP_INS_HOLE_LAST;
          state_d = S_WALK_RD;
        end else begin
          dp_op_o = DP_REJECT;
          state_d = S_DONE;
        end
      end
      S_WALK_RD: begin
        if (stat_i.idx_zero) begin
          state_d = S_PUT;
        end else begin
          dp_op_o = DP_WALK_RD;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (stat_i.gt) begin
          dp_op_o = DP_WALK_MOVE;
          if (stat_i.idx_one) state_d = S_PUT;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        dp_op_o = DP_INS_PUT;
        state_d = S_DONE;
      end
      S_RM_START: begin
        if (stat_i.pos_bad) begin
          dp_op_o = DP_INVALID;
          state_d = S_DONE;
        end else begin
          dp_op_o = DP_RM_RD;
          state_d = S_RM_TAKE;
        end
      end
      S_RM_TAKE: begin
        dp_op_o = DP_RM_TAKE;
        state_d = S_RM_SHIFT;
      end
      S_RM_SHIFT: begin
        if (stat_i.idx_lt_held) begin
          dp_op_o = DP_RM_SHIFT;
        end else begin
          dp_op_o = DP_RM_END;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          dp_op_o     = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BSST_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != S_IDLE)
  `BSST_ASSERT_IMP(a_done_free_loads, (state_q == S_DONE) && !out_valid_q, dp_op_o == DP_OUT)

endmodule

>>> rtl/core/bsst_dpath.sv
// datapath of the bounded sorted score table: entry memory, pointers, result registers
// depends on bsst_pkg and bounded_sorted_score_table_macros.svh
`include "bounded_sorted_score_table_macros.svh"

module bsst_dpath #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bsst_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                op_i,
  input  logic signed [bsst_pkg::SCORE_W-1:0] new_score_i,
  input  logic [bsst_pkg::TAG_W-1:0]          new_tag_i,
  input  logic [bsst_pkg::POS_W-1:0]          position_i,
  input  bsst_pkg::dp_op_e                    dp_op_i,
  output bsst_pkg::dp_stat_t                  stat_o,
  output logic [1:0]                          status_o,
  output logic [bsst_pkg::POS_W-1:0]          slot_o,
  output logic signed [bsst_pkg::SCORE_W-1:0] removed_score_o,
  output logic [bsst_pkg::TAG_W-1:0]          removed_tag_o,
  output logic [bsst_pkg::CNT_OUT_W-1:0]      entry_count_o
);
  import bsst_pkg::*;

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned XW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned PXW   = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned ENT_W = SCORE_W + TAG_W;

  // effective capacity: register value held to 1..CAPACITY
  function automatic logic [CW-1:0] eff_of(input logic [CFG_W-1:0] r);
    logic [XW-1:0] rx;
    rx = XW'(r);
    if (rx == '0) return CW'(1);
    else if (rx > XW'(CAPACITY)) return CW'(CAPACITY);
    else return CW'(rx);
  endfunction

  logic [CFG_W-1:0] cap_q, cap_d;
  logic [CW-1:0]    held_q, held_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    eff_cap, eff_new;
  logic [CW-1:0]    cap_m1, idx_m1, idx_m2, idx_p1;
  logic [PXW-1:0]   pos_x;

  // item and result registers
  logic                      item_op_q;
  logic signed [SCORE_W-1:0] item_score_q;
  logic [TAG_W-1:0]          item_tag_q;
  logic [POS_W-1:0]          item_pos_q;
  status_e                   res_status_q, res_status_d;
  logic [POS_W-1:0]          res_slot_q, res_slot_d;
  logic [ENT_W-1:0]          res_ent_q, res_ent_d;

  logic [1:0]           out_status_q;
  logic [POS_W-1:0]     out_slot_q;
  logic [ENT_W-1:0]     out_ent_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  // entry memory, one write and one registered read per cycle
  logic [ENT_W-1:0] mem_q [CAPACITY];
  logic [ENT_W-1:0] rd_q;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;

  assign eff_cap = eff_of(cap_q);
  assign eff_new = eff_of(cfg_wdata_i);
  assign cap_m1  = eff_cap - CW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign idx_m2  = idx_q - CW'(2);
  assign idx_p1  = idx_q + CW'(1);
  assign pos_x   = PXW'(item_pos_q);

  // status to the controller
  assign stat_o.full        = (held_q >= eff_cap);
  assign stat_o.gt          = item_score_q > $signed(rd_q[ENT_W-1:TAG_W]);
  assign stat_o.idx_zero    = (idx_q == '0);
  assign stat_o.idx_one     = (idx_q == CW'(1));
  assign stat_o.pos_bad     = (pos_x >= PXW'(held_q));
  assign stat_o.idx_lt_held = (idx_q < held_q);

  // micro-op decode
  always_comb begin
    cap_d        = cap_q;
    held_d       = held_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_ent_d    = res_ent_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    case (dp_op_i)
      DP_LOAD: begin
        res_slot_d = '0;
        res_ent_d  = '0;
      end
      DP_INS_FULL_RD: begin
        rd_en   = 1'b1;
        rd_addr = cap_m1[AW-1:0];
      end
      DP_INS_OPEN: begin
        idx_d  = held_q;
        held_d = held_q + CW'(1);
      end
      DP_INS_HOLE_LAST: begin
        idx_d = cap_m1;
      end
      DP_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[AW-1:0];
      end
      DP_WALK_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AW-1:0];
        wr_data = rd_q;
        idx_d   = idx_m1;
        rd_en   = (idx_q > CW'(1));
        rd_addr = idx_m2[AW-1:0];
      end
      DP_INS_PUT: begin
        wr_en        = 1'b1;
        wr_addr      = idx_q[AW-1:0];
        wr_data      = {item_score_q, item_tag_q};
        res_status_d = ST_INSERTED;
        res_slot_d   = POS_W'(idx_q);
      end
      DP_REJECT: begin
        res_status_d = ST_REJECTED;
      end
      DP_INVALID: begin
        res_status_d = ST_INVALID;
      end
      DP_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos_x[AW-1:0];
        idx_d   = pos_x[CW-1:0];
      end
      DP_RM_TAKE: begin
        res_ent_d = rd_q;
        idx_d     = idx_p1;
        rd_en     = (idx_p1 < held_q);
        rd_addr   = idx_p1[AW-1:0];
      end
      DP_RM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        wr_data = rd_q;
        idx_d   = idx_p1;
        rd_en   = (idx_p1 < held_q);
        rd_addr = idx_p1[AW-1:0];
      end
      DP_RM_END: begin
        held_d       = held_q - CW'(1);
        res_status_d = ST_REMOVED;
      end
      default: begin
      end
    endcase
    // register write, which the user issues only while idle (unchecked); drops the lowest entries at once
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
      if (held_q > eff_new) held_d = eff_new;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      held_q <= '0;
      idx_q  <= '0;
    end else begin
      cap_q  <= cap_d;
      held_q <= held_d;
      idx_q  <= idx_d;
    end
  end

  // item, result and output payload
  always_ff @(posedge clk_i) begin
    if (dp_op_i == DP_LOAD) begin
      item_op_q    <= op_i;
      item_score_q <= new_score_i;
      item_tag_q   <= new_tag_i;
      item_pos_q   <= position_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_ent_q    <= res_ent_d;
    if (dp_op_i == DP_OUT) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_ent_q    <= res_ent_q;
      out_cnt_q    <= CNT_OUT_W'(held_q);
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign removed_score_o = $signed(out_ent_q[ENT_W-1:TAG_W]);
  assign removed_tag_o   = out_ent_q[TAG_W-1:0];
  assign entry_count_o   = out_cnt_q;

  `BSST_ASSERT_IMP(a_held_within_cap, 1'b1, held_q <= eff_cap)
  `BSST_ASSERT_IMP(a_walk_not_at_top, dp_op_i == DP_WALK_MOVE, (idx_q != '0) && !item_op_q)
  `BSST_ASSERT_IMP(a_shift_in_range, dp_op_i == DP_RM_SHIFT, (idx_q != '0) && item_op_q)

endmodule

>>> rtl/core/bounded_sorted_score_table.sv
// top level of the bounded sorted score table (top-k list)
// depends on bsst_pkg, bsst_ctrl and bsst_dpath
//
//   channel  handshake                 payload
//   in       in_valid_i / in_stall_o   op_i, new_score_i, new_tag_i, position_i
//   out      out_valid_o / out_stall_i status_o, slot_o, removed_score_o,
//                                      removed_tag_o, entry_count_o
//   cfg      cfg_we_i                  cfg_wdata_i (capacity_in_use)
//
// an insert walks up past each entry that it beats, with an extra read and compare
// of the last entry when the table is full; a remove shifts each entry behind
// position p up by one; a rejected insert and an invalid remove skip the walk
// the walk moves one entry per cycle with one read and one write on the entry memory
// one item is worked at a time; in_stall_o is high from accept until the result
// is handed to the output register, which holds it while out_stall_i is high
// reset clears the count and sets the capacity register to 10; entries need no clear

module bounded_sorted_score_table #(
  parameter int unsigned CAPACITY = bsst_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic signed [bsst_pkg::SCORE_W-1:0] new_score_i,
  input  logic [bsst_pkg::TAG_W-1:0]          new_tag_i,
  input  logic [bsst_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [bsst_pkg::POS_W-1:0]          slot_o,
  output logic signed [bsst_pkg::SCORE_W-1:0] removed_score_o,
  output logic [bsst_pkg::TAG_W-1:0]          removed_tag_o,
  output logic [bsst_pkg::CNT_OUT_W-1:0]      entry_count_o,
  input  logic                                cfg_we_i,
  input  logic [bsst_pkg::CFG_W-1:0]          cfg_wdata_i
);
  import bsst_pkg::*;

  dp_op_e   dp_op;
  dp_stat_t dp_stat;

  // sequencer
  bsst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .dp_op_o     (dp_op)
  );

  // entry store and result path
  bsst_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .new_score_i     (new_score_i),
    .new_tag_i       (new_tag_i),
    .position_i      (position_i),
    .dp_op_i         (dp_op),
    .stat_o          (dp_stat),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .removed_score_o (removed_score_o),
    .removed_tag_o   (removed_tag_o),
    .entry_count_o   (entry_count_o)
  );

endmodule

>>> test/bsst_table_checker.sv
// operation codes for the testbench and the result checker of the score table
// the checker watches both channels and the capacity port and predicts each result
// depends on bsst_pkg for widths and status codes
package bsst_tb_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } table_op_e;

endpackage

module bsst_table_checker
  import bsst_pkg::*;
  import bsst_tb_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      op_i,
  input  logic signed [SCORE_W-1:0] new_score_i,
  input  logic [TAG_W-1:0]          new_tag_i,
  input  logic [POS_W-1:0]          position_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [1:0]                status_i,
  input  logic [POS_W-1:0]          slot_i,
  input  logic signed [SCORE_W-1:0] removed_score_i,
  input  logic [TAG_W-1:0]          removed_tag_i,
  input  logic [CNT_OUT_W-1:0]      entry_count_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e                   status;
    logic [POS_W-1:0]          slot;
    logic signed [SCORE_W-1:0] removed_score;
    logic [TAG_W-1:0]          removed_tag;
    logic [CNT_OUT_W-1:0]      entry_count;
  } table_outcome_t;

  // shadow copy of the table, kept in descending score order
  logic signed [SCORE_W-1:0] score_mem [CAPACITY];
  logic [TAG_W-1:0]          tag_mem   [CAPACITY];
  int unsigned               held_entries;
  logic [CFG_W-1:0]          capacity_reg;
  table_outcome_t            pending_outcomes [$];

  // register value held to 1..CAPACITY
  function automatic int unsigned active_slots();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > CAPACITY) return CAPACITY;
    return capacity_reg;
  endfunction

  // apply one item to the shadow table and return the result it gives
  function automatic table_outcome_t predict_table_op(table_op_e kind,
                                                      logic signed [SCORE_W-1:0] score,
                                                      logic [TAG_W-1:0] tag,
                                                      logic [POS_W-1:0] pos);
    table_outcome_t res;
    int unsigned    cap;
    int unsigned    hole;
    bit             admit;
    res = '0;
    cap = active_slots();
    if (held_entries > cap) held_entries = cap;
    if (kind == OP_INSERT) begin
      admit = 1'b1;
      // full table: the newcomer must beat the last entry, which it replaces
      if (held_entries >= cap) begin
        admit = score > score_mem[cap-1];
        hole  = cap - 1;
      end else begin
        hole = held_entries;
        held_entries++;
      end
      if (admit) begin
        // walk up past strictly lower scores, equal scores stay ahead
        while (hole > 0 && score > score_mem[hole-1]) begin
          score_mem[hole] = score_mem[hole-1];
          tag_mem[hole]   = tag_mem[hole-1];
          hole--;
        end
        score_mem[hole] = score;
        tag_mem[hole]   = tag;
        res.status      = ST_INSERTED;
        res.slot        = hole[POS_W-1:0];
      end else begin
        res.status = ST_REJECTED;
      end
    end else if (pos >= held_entries) begin
      res.status = ST_INVALID;
    end else begin
      // hand back the entry and close the gap
      res.status        = ST_REMOVED;
      res.removed_score = score_mem[pos];
      res.removed_tag   = tag_mem[pos];
      for (int unsigned j = pos + 1; j < held_entries; j++) begin
        score_mem[j-1] = score_mem[j];
        tag_mem[j-1]   = tag_mem[j];
      end
      held_entries--;
    end
    res.entry_count = held_entries[CNT_OUT_W-1:0];
    return res;
  endfunction

  // watch the channels at each edge: results first, then capacity, then new items
  always @(posedge clk_i) begin : watch
    table_outcome_t want;
    if (!rst_ni) begin
      held_entries = 0;
      capacity_reg = CAP_RESET;
      pending_outcomes.delete();
      fail_count_o = 0;
      results_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (pending_outcomes.size() == 0) begin
          $error("result with no item outstanding: status %0d entry_count %0d",
                 status_i, entry_count_i);
          fail_count_o++;
        end else begin
          want = pending_outcomes.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %s, actual %0d", want.status.name(), status_i);
            fail_count_o++;
          end
          if (slot_i !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot_i);
            fail_count_o++;
          end
          if (removed_score_i !== want.removed_score) begin
            $error("removed_score: expected %0d, actual %0d",
                   want.removed_score, removed_score_i);
            fail_count_o++;
          end
          if (removed_tag_i !== want.removed_tag) begin
            $error("removed_tag: expected 0x%04h, actual 0x%04h",
                   want.removed_tag, removed_tag_i);
            fail_count_o++;
          end
          if (entry_count_i !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count_i);
            fail_count_o++;
          end
        end
      end
      // a lower capacity drops the lowest entries at once
      if (cfg_we_i) begin
        capacity_reg = cfg_wdata_i;
        if (held_entries > active_slots()) held_entries = active_slots();
      end
      if (in_valid_i && !in_stall_i) begin
        pending_outcomes.push_back(predict_table_op(table_op_e'(op_i), new_score_i,
                                                    new_tag_i, position_i));
      end
    end
    pending_o = pending_outcomes.size();
  end

endmodule

>>> test/tb_bounded_sorted_score_table.sv
// testbench top for the bounded sorted score table: clock, reset, stimulus and verdict
// depends on bsst_pkg, bsst_tb_pkg, bsst_table_checker and the block itself
module tb_bounded_sorted_score_table;
  timeunit 1ns;
  timeprecision 1ps;

  import bsst_pkg::*;
  import bsst_tb_pkg::*;

  localparam int unsigned PHASES           = 14;
  localparam int unsigned ITEMS_PER_PHASE  = 124;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES    = 24;
  localparam int unsigned TIMEOUT_CYCLES   = 600_000;

  logic                      clk;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic                      op            = OP_INSERT;
  logic signed [SCORE_W-1:0] new_score     = '0;
  logic [TAG_W-1:0]          new_tag       = '0;
  logic [POS_W-1:0]          position      = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic [1:0]                status;
  logic [POS_W-1:0]          slot;
  logic signed [SCORE_W-1:0] removed_score;
  logic [TAG_W-1:0]          removed_tag;
  logic [CNT_OUT_W-1:0]      entry_count;
  logic                      cfg_we        = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata     = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  int unsigned inserts_sent  = 0;
  int unsigned removes_sent  = 0;
  int unsigned cap_writes    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned tx_run        = 0;
  bit          tx_busy       = 1'b0;

  bounded_sorted_score_table #(
    .CAPACITY(CAPACITY_DEF)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .new_score_i    (new_score),
    .new_tag_i      (new_tag),
    .position_i     (position),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .slot_o         (slot),
    .removed_score_o(removed_score),
    .removed_tag_o  (removed_tag),
    .entry_count_o  (entry_count),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  bsst_table_checker #(
    .CAPACITY(CAPACITY_DEF)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (op),
    .new_score_i    (new_score),
    .new_tag_i      (new_tag),
    .position_i     (position),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .slot_i         (slot),
    .removed_score_i(removed_score),
    .removed_tag_i  (removed_tag),
    .entry_count_i  (entry_count),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // offer one item after a random gap and hold it until accepted
  task automatic offer_item(table_op_e kind, logic signed [SCORE_W-1:0] score,
                            logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
    int unsigned gap;
    if (tx_run == 0) begin
      tx_run  = $urandom_range(1, 40);
      tx_busy = $urandom_range(0, 2) != 0;
    end
    tx_run--;
    gap = tx_busy ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    new_score <= score;
    new_tag   <= tag;
    position  <= pos;
    do @(posedge clk); while (in_stall);
    if (kind == OP_INSERT) inserts_sent++;
    else removes_sent++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // capacity write, only issued while the block is idle
  task automatic set_capacity(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  // result side: random stalls in runs, plus long holds on request
  initial begin : result_sink
    int unsigned hold;
    int unsigned rx_run;
    bit          rx_busy;
    rx_run  = 0;
    rx_busy = 1'b0;
    forever begin
      if (rx_run == 0) begin
        rx_run  = $urandom_range(1, 40);
        rx_busy = $urandom_range(0, 2) != 0;
      end
      rx_run--;
      hold = rx_busy ? $urandom_range(0, 5) : 0;
      if (holds_done != hold_requests) begin
        holds_done++;
        hold = LONG_HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // stimulus
  initial begin : stimulus
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] last_score;
    logic [POS_W-1:0]          pos;
    table_op_e                 kind;
    int unsigned               insert_pct;
    int unsigned               pick;
    logic [CFG_W-1:0]          cap_value;
    logic [CFG_W-1:0]          cap_plan [10];
    cap_plan   = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd10, 5'd17, 5'd8, 5'd2, 5'd15};
    last_score = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // remove from the empty table at reset capacity
    offer_item(OP_REMOVE, '0, '0, 4'd0);
    drain_results();

    // directed items on a four-slot table
    set_capacity(5'd4);
    offer_item(OP_INSERT, 32'sd0, 16'h0000, 4'd0);
    offer_item(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF, 4'd15);
    offer_item(OP_INSERT, 32'sh8000_0000, 16'h0001, 4'd0);
    // tie goes behind the held zero
    offer_item(OP_INSERT, 32'sd0, 16'h0002, 4'd0);
    // full: equal to the last score is turned away
    offer_item(OP_INSERT, 32'sh8000_0000, 16'h0003, 4'd0);
    offer_item(OP_INSERT, 32'sh8000_0001, 16'h0004, 4'd0);
    offer_item(OP_INSERT, 32'sd0, 16'h0005, 4'd0);
    offer_item(OP_INSERT, 32'sh7FFF_FFFF, 16'h0006, 4'd0);
    offer_item(OP_INSERT, -32'sd1, 16'h0007, 4'd0);
    // positions past the held entries, then removes and inserts in range
    offer_item(OP_REMOVE, 32'sh7FFF_FFFF, 16'hFFFF, 4'd15);
    offer_item(OP_REMOVE, '0, '0, 4'd4);
    offer_item(OP_REMOVE, '0, '0, 4'd3);
    offer_item(OP_REMOVE, '0, '0, 4'd0);
    offer_item(OP_INSERT, 32'sh4000_0000, 16'hAAAA, 4'd0);
    offer_item(OP_INSERT, -32'sd5, 16'h5555, 4'd0);
    offer_item(OP_REMOVE, '0, '0, 4'd1);
    // empty it out and one past empty
    repeat (4) offer_item(OP_REMOVE, '0, '0, 4'd0);
    drain_results();

    // random phases, each under its own capacity
    for (int unsigned k = 0; k < PHASES; k++) begin
      cap_value = (k < 10) ? cap_plan[k] : CFG_W'($urandom_range(0, 31));
      set_capacity(cap_value);
      if (k == 1 || k == 6) hold_requests++;
      insert_pct = (k == 0) ? 90 : $urandom_range(35, 80);
      repeat (ITEMS_PER_PHASE) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        pick = $urandom_range(0, 9);
        // extremes, small values for ties, repeats of a recent score, full range
        case (pick)
          0:       score = 32'sh7FFF_FFFF;
          1:       score = 32'sh8000_0000;
          2, 3, 4: score = int'($urandom_range(0, 16)) - 8;
          5:       score = last_score;
          default: score = $urandom;
        endcase
        if (kind == OP_INSERT) last_score = score;
        pos = ($urandom_range(0, 2) != 0) ? POS_W'($urandom_range(0, 3))
                                          : POS_W'($urandom_range(0, 15));
        offer_item(kind, score, TAG_W'($urandom_range(0, 65535)), pos);
      end
      drain_results();
    end

    $display("covered %0d inserts and %0d removes over %0d capacity writes, %0d long holds",
             inserts_sent, removes_sent, cap_writes, holds_done);
    $display("%0d results compared field by field with the predicted table", results);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bsst_pkg.sv
rtl/core/bsst_ctrl.sv
rtl/core/bsst_dpath.sv
rtl/core/bounded_sorted_score_table.sv
test/bsst_table_checker.sv
test/tb_bounded_sorted_score_table.sv
